### hdl/bdq_pkg.sv
package bdq_pkg;

  // Default list capacity in records
  localparam int unsigned CapacityDef = 256;

  // Operation codes
  localparam logic [2:0] OP_INS_HEAD = 3'd0;
  localparam logic [2:0] OP_INS_TAIL = 3'd1;
  localparam logic [2:0] OP_REM_HEAD = 3'd2;
  localparam logic [2:0] OP_REM_TAIL = 3'd3;
  localparam logic [2:0] OP_RD_HEAD  = 3'd4;
  localparam logic [2:0] OP_RD_TAIL  = 3'd5;
  localparam logic [2:0] OP_RD_IDX   = 3'd6;
  localparam logic [2:0] OP_WR_IDX   = 3'd7;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         sym;
  } rec_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [8:0]         position_index;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic [7:0]         symbol_code;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [7:0]         out_symbol;
    logic [1:0]         status;
    logic [8:0]         element_count;
  } out_t;

  // Per-transaction info waiting for the memory read data
  typedef struct packed {
    logic       rd_hit;
    logic [1:0] status;
    logic [8:0] count;
  } stage_t;

endpackage

### hdl/bdq_ram.sv
module bdq_ram
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = CapacityDef,
  parameter int unsigned AW    = $clog2(CapacityDef)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  rec_t          wdata_i,
  output rec_t          rdata_o
);

  rec_t mem [DEPTH];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/bounded_deque_with_index_access_top.sv
// Bounded deque of position records with head, tail and indexed access.
// Pipeline: an accepted input transaction passes the memory read and stage
//   register, then the result register, before its result is presented.
// Throughput: one transaction per cycle unless the output stalls, set by the
//   single-port record memory (at most one read or one write per transaction).
// Reset clears the head pointer, the element count and all valid flags; the
//   record memory is not cleared, since only written entries are ever read.
module bounded_deque_with_index_access_top
  import bdq_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  // Pointer, count, compare and slot-sum widths
  localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > 9) ? CW : 9;
  localparam int unsigned SW = XW + 1;

  logic [PW-1:0] head_q, head_d, head_dec;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          s1_valid_q, out_valid_q;
  stage_t        s1_q, s1_d;
  out_t          out_q;

  logic          accept, advance;
  logic          full, empty;
  logic          we, re, use_head_dec;
  logic [XW-1:0] logical, idx_ext, cnt_ext;
  logic [SW-1:0] sum;
  logic [PW-1:0] slot, addr;
  rec_t          wrec, rrec;

  // Handshake: the result register frees up when empty or taken downstream;
  // the memory stage moves on whenever the result register frees up.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  assign full     = (cnt_q == CW'(CAPACITY));
  assign empty    = (cnt_q == '0);
  assign idx_ext  = XW'(in_data_i.position_index);
  assign cnt_ext  = XW'(cnt_q);
  assign head_dec = (head_q == '0) ? PW'(CAPACITY - 1) : head_q - PW'(1);

  // Decode the operation and update pointer and count
  always_comb begin
    head_d       = head_q;
    cnt_d        = cnt_q;
    we           = 1'b0;
    re           = 1'b0;
    use_head_dec = 1'b0;
    logical      = '0;
    s1_d.rd_hit  = 1'b0;
    s1_d.status  = ST_OK;
    case (in_data_i.opcode)
      OP_INS_HEAD: begin
        if (full) begin
          s1_d.status = ST_FULL;
        end else begin
          head_d       = head_dec;
          cnt_d        = cnt_q + CW'(1);
          we           = 1'b1;
          use_head_dec = 1'b1;
        end
      end
      OP_INS_TAIL: begin
        logical = cnt_ext;
        if (full) begin
          s1_d.status = ST_FULL;
        end else begin
          cnt_d = cnt_q + CW'(1);
          we    = 1'b1;
        end
      end
      OP_REM_HEAD: begin
        if (empty) begin
          s1_d.status = ST_EMPTY;
        end else begin
          head_d = (head_q == PW'(CAPACITY - 1)) ? '0 : head_q + PW'(1);
          cnt_d  = cnt_q - CW'(1);
        end
      end
      OP_REM_TAIL: begin
        if (empty) begin
          s1_d.status = ST_EMPTY;
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      OP_RD_HEAD: begin
        if (empty) begin
          s1_d.status = ST_EMPTY;
        end else begin
          re          = 1'b1;
          s1_d.rd_hit = 1'b1;
        end
      end
      OP_RD_TAIL: begin
        logical = cnt_ext - XW'(1);
        if (empty) begin
          s1_d.status = ST_EMPTY;
        end else begin
          re          = 1'b1;
          s1_d.rd_hit = 1'b1;
        end
      end
      OP_RD_IDX: begin
        logical = idx_ext;
        if (idx_ext >= XW'(CAPACITY)) begin
          s1_d.status = ST_RANGE;
        end else if (idx_ext < cnt_ext) begin
          re          = 1'b1;
          s1_d.rd_hit = 1'b1;
        end
      end
      OP_WR_IDX: begin
        logical = idx_ext;
        if (idx_ext >= cnt_ext) begin
          s1_d.status = ST_RANGE;
        end else begin
          we = 1'b1;
        end
      end
      default: begin
        s1_d.status = ST_OK;
      end
    endcase
    // Report the count after this operation, masked to the field width
    s1_d.count = 9'(cnt_d);
  end

  // Ring slot: head plus logical index, wrapped by one compare and subtract
  assign sum       = SW'(head_q) + SW'(logical);
  assign slot      = (sum >= SW'(CAPACITY)) ? PW'(sum - SW'(CAPACITY)) : PW'(sum);
  assign addr      = use_head_dec ? head_dec : slot;

  assign wrec.x   = in_data_i.x_coord;
  assign wrec.y   = in_data_i.y_coord;
  assign wrec.sym = in_data_i.symbol_code;

  bdq_ram #(
    .DEPTH (CAPACITY),
    .AW    (PW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (accept && we),
    .re_i    (accept && re),
    .addr_i  (addr),
    .wdata_i (wrec),
    .rdata_o (rrec)
  );

  // Advance pointer and count on every accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        head_q <= head_d;
        cnt_q  <= cnt_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Hold stage info with its pending memory read; drop a missed read to zero
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (advance && s1_valid_q) begin
      out_q.out_x         <= s1_q.rd_hit ? rrec.x : '0;
      out_q.out_y         <= s1_q.rd_hit ? rrec.y : '0;
      out_q.out_symbol    <= s1_q.rd_hit ? rrec.sym : '0;
      out_q.status        <= s1_q.status;
      out_q.element_count <= s1_q.count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
